>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ADTS frame scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/afs_pkg.sv
// Types, constants and header decode shared by the ADTS frame scanner modules.
`default_nettype none

package afs_pkg;

	localparam int AFS_OFFSET_BITS = 32;

	localparam logic [7:0] AFS_SYNC0      = 8'hFF;
	localparam logic [7:0] AFS_SYNC1_MASK = 8'hF6;
	localparam logic [7:0] AFS_SYNC1_VAL  = 8'hF0;
	localparam logic [3:0] AFS_RATE_MAX   = 4'd11;
	localparam int         AFS_MIN_SPAN   = 11;
	localparam int         AFS_WIN_LAG    = 5;

	// Register map: index carried by paddr[2].
	localparam logic AFS_REG_STREAM_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_NONE  = 2'd2
	} kind_t;

	// Six-byte window, index 0 oldest, index 5 newest.
	typedef logic [5:0][7:0] win_t;

	typedef struct packed {
		logic [1:0] profile;
		logic [3:0] rate;
		logic [2:0] chan;
		logic       id;
	} fhdr_t;

	typedef struct packed {
		logic        sync;
		fhdr_t       fields;
		logic [12:0] flen;
	} hdr_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] number;
		logic [31:0] offset;
		logic [12:0] bytes;
		logic [31:0] total;
		fhdr_t       fields;
	} rec_t;

	function automatic hdr_t afs_decode(input win_t w);
		hdr_t h;
		h.sync          = (w[0] == AFS_SYNC0) && ((w[1] & AFS_SYNC1_MASK) == AFS_SYNC1_VAL);
		h.fields.profile = w[2][7:6];
		h.fields.rate    = w[2][5:2];
		h.fields.chan    = {w[2][0], w[3][7:6]};
		h.fields.id      = w[1][3];
		h.flen          = {w[3][1:0], w[4], w[5][7:5]};
		return h;
	endfunction

endpackage

`default_nettype wire

>>> rtl/afs_window.sv
// Six-byte shift window with the ADTS header decode of the shifted window.
`default_nettype none

module afs_window import afs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire logic [7:0] new_byte,
	output hdr_t            hdr
);

	win_t win_q;
	win_t win_d;

	// The header is checked on the window as it stands after this byte enters.
	always_comb begin
		win_d    = {new_byte, win_q[5:1]};
		hdr      = afs_decode(win_d);
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= win_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/afs_scan.sv
// Scan state: byte position, next candidate, frame count, length sum, first header.
`default_nettype none

module afs_scan import afs_pkg::*; #(
	parameter int OFFSET_BITS = AFS_OFFSET_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [31:0] stream_length,
	input  hdr_t             hdr,
	output logic             in_range,
	output logic             emit,
	output rec_t             rec
);

	localparam int CW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS:0]   cand_q;
	logic [OFFSET_BITS:0]   cand_d;
	logic [31:0]            found_q;
	logic [31:0]            sum_q;
	logic [31:0]            sum_d;
	fhdr_t                  fhdr_q;
	fhdr_t                  fhdr_d;

	logic [OFFSET_BITS-1:0] c;
	logic [CW-1:0]          p_ext;
	logic [CW-1:0]          len_ext;
	logic [CW-1:0]          c_ext;
	logic [32:0]            sum_wide;
	logic [12:0]            adv_len;
	logic                   cand_ok;
	logic                   first;
	logic                   hit;
	logic                   last;
	logic                   upd;

	always_comb begin
		p_ext    = CW'(pos_q);
		len_ext  = CW'(stream_length);
		c        = pos_q - OFFSET_BITS'(AFS_WIN_LAG);
		c_ext    = CW'(c);
		in_range = p_ext < len_ext;
		last     = (p_ext + CW'(1)) == len_ext;
		cand_ok  = (pos_q >= OFFSET_BITS'(AFS_WIN_LAG))
			&& ((c_ext + CW'(AFS_MIN_SPAN)) <= len_ext)
			&& ({1'b0, c} == cand_q);
		first    = (found_q == 32'd0);
		hit      = cand_ok && hdr.sync && !(first && (hdr.fields.rate > AFS_RATE_MAX));
		adv_len  = (hdr.flen != 13'd0) ? hdr.flen : 13'd1;

		if (hit) begin
			cand_d = {1'b0, c} + (OFFSET_BITS+1)'(adv_len);
		end else if (cand_ok) begin
			cand_d = {1'b0, c} + (OFFSET_BITS+1)'(1);
		end else begin
			cand_d = cand_q;
		end

		sum_wide = {1'b0, sum_q} + 33'(hdr.flen);
		sum_d    = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
		fhdr_d   = (hit && first) ? hdr.fields : fhdr_q;

		emit = in_range && (hit || last);
		upd  = step && in_range;

		if (hit) begin
			rec.kind   = KIND_FRAME;
			rec.number = found_q;
			rec.offset = c_ext[31:0];
			rec.bytes  = hdr.flen;
			rec.total  = sum_d;
			rec.fields = fhdr_d;
		end else if (!first) begin
			rec.kind   = KIND_DONE;
			rec.number = found_q;
			rec.offset = 32'd0;
			rec.bytes  = 13'd0;
			rec.total  = sum_q;
			rec.fields = fhdr_q;
		end else begin
			rec.kind   = KIND_NONE;
			rec.number = 32'd0;
			rec.offset = 32'd0;
			rec.bytes  = 13'd0;
			rec.total  = 32'd0;
			rec.fields = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			cand_q  <= '0;
			found_q <= '0;
			sum_q   <= '0;
			fhdr_q  <= '0;
		end else if (upd) begin
			pos_q  <= pos_q + OFFSET_BITS'(1);
			cand_q <= cand_d;
			fhdr_q <= fhdr_d;
			if (hit) begin
				sum_q <= sum_d;
				if (found_q != 32'hFFFF_FFFF) begin
					found_q <= found_q + 32'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/adts_frame_scanner.sv
// ADTS frame scanner top level: byte channel, record channel and register port.
//
// Stream bytes arrive on the stream channel (stream_valid, stream_stall,
// stream_byte), one transaction per byte, offsets counted from zero. The
// block keeps a six-byte window and checks for an ADTS header at each
// candidate offset; a frame found gives one record transaction on the
// record channel, and the last byte of the stream gives a summary record.
// Bytes at or past stream_length are dropped and give nothing.
// stream_length is written through the APB port at address 0; pready is
// always high. It is to be written only while the block is idle; the block
// itself does not enforce this. A byte enters an input register when it is
// accepted; its record, if any, is written to the output register when the
// byte steps on, and record_valid then rises; the record is taken when
// record_stall is low. One byte is taken in every cycle while the receiver
// does not stall a held record: the whole per-byte step (window shift, header compare,
// candidate add and length-sum add) sits between those two registers.
// When the receiver stalls, the output register holds its record, the
// input register holds the waiting byte, and stream_stall rises until the
// record is taken. Reset clears the scan state, the count and the sum,
// empties both registers and sets stream_length to zero.
`default_nettype none
`include "assert_macros.svh"

module adts_frame_scanner import afs_pkg::*; #(
	parameter int OFFSET_BITS = AFS_OFFSET_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Stream byte channel.
	input  wire logic        stream_valid,
	output logic             stream_stall,
	input  wire logic [7:0]  stream_byte,
	// Record channel.
	output logic             record_valid,
	input  wire logic        record_stall,
	output logic [1:0]       record_kind,
	output logic [31:0]      frame_number,
	output logic [31:0]      frame_offset,
	output logic [12:0]      frame_bytes,
	output logic [31:0]      length_total,
	output logic [1:0]       profile,
	output logic [3:0]       rate_index,
	output logic [2:0]       channel_config,
	output logic             mpeg_two,
	// Register port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	rec_t        rec_s2;
	logic [31:0] length_q;

	logic        adv;
	logic        step;
	logic        in_range;
	logic        emit;
	hdr_t        hdr;
	rec_t        rec;

	// The output register is free when empty or when its record leaves now.
	assign adv          = !valid_s2 || !record_stall;
	assign step         = valid_s1 && adv;
	assign stream_stall = valid_s1 && !adv;

	// Register port. A single 32-bit register; paddr[2] selects the index.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == AFS_REG_STREAM_LENGTH) ? length_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == AFS_REG_STREAM_LENGTH)) begin
			length_q <= pwdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stream_stall) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && !stream_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	// The window only moves for bytes inside the stream.
	afs_window u_window (
		.clk      (clk),
		.shift_en (step && in_range),
		.new_byte (byte_s1),
		.hdr      (hdr)
	);

	afs_scan #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.stream_length (length_q),
		.hdr           (hdr),
		.in_range      (in_range),
		.emit          (emit),
		.rec           (rec)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rec_s2 <= rec;
		end
	end

	assign record_valid   = valid_s2;
	assign record_kind    = rec_s2.kind;
	assign frame_number   = rec_s2.number;
	assign frame_offset   = rec_s2.offset;
	assign frame_bytes    = rec_s2.bytes;
	assign length_total   = rec_s2.total;
	assign profile        = rec_s2.fields.profile;
	assign rate_index     = rec_s2.fields.rate;
	assign channel_config = rec_s2.fields.chan;
	assign mpeg_two       = rec_s2.fields.id;

	// The input side only stalls behind a record that is itself held.
	`AFS_ASSERT_IMPL(a_stall_cause, clk, arst_n, stream_stall,
		valid_s2 && record_stall, "stream stalled without a held record")

	// A byte taken while the input register moves is in that register next cycle.
	`AFS_ASSERT_NEXT(a_byte_loaded, clk, arst_n, stream_valid && !stream_stall,
		valid_s1, "accepted byte did not reach the input register")

	// Summary records carry no frame offset or frame length.
	`AFS_ASSERT_IMPL(a_summary_clean, clk, arst_n,
		valid_s2 && (rec_s2.kind != KIND_FRAME),
		(rec_s2.offset == 32'd0) && (rec_s2.bytes == 13'd0),
		"summary record with frame offset or length")

endmodule

`default_nettype wire

>>> tb/adts_frame_scanner_tb.sv
// Self-checking testbench for the ADTS frame scanner: byte streams checked record by record.
`timescale 1ns / 1ps

module adts_frame_scanner_tb;
	import afs_pkg::*;

	// Cycles allowed after the last expected record before the register is touched again.
	// A byte that gives no record may still sit in the two pipeline registers.
	localparam int SETTLE_CYCLES = 6;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        stream_valid = 1'b0;
	logic        stream_stall;
	logic [7:0]  stream_byte  = 8'h00;
	logic        record_valid;
	logic        record_stall = 1'b0;
	logic [1:0]  record_kind;
	logic [31:0] frame_number;
	logic [31:0] frame_offset;
	logic [12:0] frame_bytes;
	logic [31:0] length_total;
	logic [1:0]  profile;
	logic [3:0]  rate_index;
	logic [2:0]  channel_config;
	logic        mpeg_two;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	adts_frame_scanner u_top (.*);

	always #1 clk = ~clk;

	// Percentages of cycles in which the sender holds back a byte and the receiver stalls.
	int gap_pct   = 29;
	int stall_pct = 68;

	int error_count       = 0;
	int bytes_sent        = 0;
	int frames_checked    = 0;
	int summaries_checked = 0;
	int lengths_written   = 0;

	// Scanner state as the testbench expects it to be, updated once per accepted byte.
	logic [7:0]  win_bytes [6] = '{default: 8'h00};
	logic [31:0] scan_pos      = '0;
	logic [32:0] cand_offset   = '0;
	logic [31:0] frame_count   = '0;
	logic [31:0] len_total     = '0;
	fhdr_t       latched_hdr   = '0;
	logic [31:0] len_reg       = '0;

	// Records the scanner owes us, oldest first.
	rec_t pending_records [$];

	// The stream being assembled for the next scan, with a flag per byte that tells
	// whether the candidate jumps over it (frame bodies) or walks through it.
	logic [7:0] stream_buf [$];
	bit         guard_buf [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	// Advances the expected scanner state by one accepted byte. Returns 1 when the byte
	// produces a record, which is then placed in rec.
	function automatic bit scan_byte(input logic [7:0] b, output rec_t rec);
		logic [33:0] c;
		logic [12:0] flen;
		logic [32:0] sum;
		logic [3:0]  rate;
		bit          sync_ok;
		bit          hit;
		rec = '0;
		hit = 1'b0;
		// Bytes at or past the configured end are dropped without touching the state.
		if (scan_pos >= len_reg)
			return 1'b0;
		for (int i = 0; i < 5; i++)
			win_bytes[i] = win_bytes[i + 1];
		win_bytes[5] = b;

		// The window now starts at offset scan_pos - 5. A header is only looked at when
		// that offset is the pending candidate and a full minimum frame still fits.
		if (scan_pos >= 32'd5) begin
			c = {2'b00, scan_pos} - 34'd5;
			if (c + 34'd11 <= {2'b00, len_reg} && c == {1'b0, cand_offset}) begin
				sync_ok = (win_bytes[0] == AFS_SYNC0) &&
					((win_bytes[1] & AFS_SYNC1_MASK) == AFS_SYNC1_VAL);
				rate = win_bytes[2][5:2];
				if (!sync_ok || (frame_count == 0 && rate > AFS_RATE_MAX)) begin
					cand_offset = c[32:0] + 33'd1;
				end else begin
					// The first accepted frame fixes the stream parameters for good.
					if (frame_count == 0) begin
						latched_hdr.profile = win_bytes[2][7:6];
						latched_hdr.rate    = rate;
						latched_hdr.chan    = {win_bytes[2][0], win_bytes[3][7:6]};
						latched_hdr.id      = win_bytes[1][3];
					end
					flen = {win_bytes[3][1:0], win_bytes[4], win_bytes[5][7:5]};
					sum = {1'b0, len_total} + {20'b0, flen};
					len_total = sum[32] ? '1 : sum[31:0];
					rec.kind   = KIND_FRAME;
					rec.number = frame_count;
					rec.offset = c[31:0];
					rec.bytes  = flen;
					rec.total  = len_total;
					rec.fields = latched_hdr;
					hit = 1'b1;
					if (frame_count != '1)
						frame_count++;
					// A zero length would stall the scan, so it moves on by one byte.
					cand_offset = c[32:0] + ((flen != 0) ? {20'b0, flen} : 33'd1);
				end
			end
		end

		// The last byte of the stream closes the scan with a summary record.
		if (!hit && {1'b0, scan_pos} + 33'd1 == {1'b0, len_reg}) begin
			if (frame_count != 0) begin
				rec.kind   = KIND_DONE;
				rec.number = frame_count;
				rec.total  = len_total;
				rec.fields = latched_hdr;
			end else begin
				rec.kind = KIND_NONE;
			end
			hit = 1'b1;
		end
		scan_pos++;
		return hit;
	endfunction

	// Offers one byte, holds it until the scanner takes it, and predicts its record.
	task automatic send_byte(input logic [7:0] b);
		rec_t rec;
		while ($urandom_range(99) < gap_pct) begin
			stream_valid <= 1'b0;
			@(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte  <= b;
		do
			@(posedge clk);
		while (stream_stall);
		if (scan_byte(b, rec))
			pending_records.push_back(rec);
		bytes_sent++;
	endtask

	// Stops the byte channel and waits until the scanner has nothing left to deliver.
	task automatic drain_records();
		stream_valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of stream_length, followed by a read that must return the new value.
	task automatic write_length(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {AFS_REG_STREAM_LENGTH, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		len_reg = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== value)
			report_mismatch("stream_length read back", prdata, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		lengths_written++;
	endtask

	task automatic add_noise(input int n);
		repeat (n) begin
			stream_buf.push_back(8'($urandom));
			guard_buf.push_back(1'b0);
		end
	endtask

	// Six header bytes. The sync bytes are always kept as they are; the other four are
	// kept only when the frame is long enough for the candidate to jump past them.
	task automatic add_header(input logic [12:0] flen, input logic [1:0] prof,
			input logic [3:0] rate, input logic [2:0] chan, input bit id, input bit guarded);
		logic [7:0]  hb [6];
		logic [31:0] r;
		r = $urandom;
		hb[0] = AFS_SYNC0;
		hb[1] = {4'hF, id, 2'b00, r[0]};
		hb[2] = {prof, rate, r[1], chan[2]};
		hb[3] = {chan[1:0], r[5:2], flen[12:11]};
		hb[4] = flen[10:3];
		hb[5] = {flen[2:0], r[10:6]};
		foreach (hb[i]) begin
			stream_buf.push_back(hb[i]);
			guard_buf.push_back(i < 2 || guarded);
		end
	endtask

	// A frame whose length field matches the bytes placed, so the next candidate lands
	// right after it. Lengths below six leave the candidate inside the header.
	task automatic add_frame(input int flen, input logic [1:0] prof, input logic [3:0] rate,
			input logic [2:0] chan, input bit id);
		add_header(13'(flen), prof, rate, chan, id, flen >= 6);
		for (int i = 6; i < flen; i++) begin
			stream_buf.push_back(8'($urandom));
			guard_buf.push_back(1'b1);
		end
	endtask

	task automatic add_random_frame(input int flen);
		add_frame(flen, 2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom));
	endtask

	// Sets the stream end just past the assembled bytes (or to the maximum), then sends
	// them. Bytes walked one at a time must not fake a sync pattern after a 0xFF, so
	// such a byte gets bit 4 flipped, which moves it out of the sync pattern.
	task automatic run_stream(input bit open_end);
		for (int i = 1; i < stream_buf.size(); i++)
			if (!guard_buf[i] && stream_buf[i - 1] == AFS_SYNC0 &&
					(stream_buf[i] & AFS_SYNC1_MASK) == AFS_SYNC1_VAL)
				stream_buf[i] ^= 8'h10;
		write_length(open_end ? '1 : scan_pos + 32'(stream_buf.size()));
		foreach (stream_buf[i])
			send_byte(stream_buf[i]);
		stream_buf.delete();
		guard_buf.delete();
		drain_records();
	endtask

	// With the reset length of zero, and again after writing zero, every byte is dropped.
	task automatic test_ignored_at_reset();
		repeat (3) send_byte(8'($urandom));
		drain_records();
		write_length('0);
		repeat (2) send_byte(8'($urandom));
		drain_records();
	endtask

	// A stream shorter than one minimum frame: nothing is checked and the scan ends empty.
	// Five bytes keep the window from passing the first candidate.
	task automatic test_short_stream();
		repeat (5) begin
			stream_buf.push_back(8'($urandom_range(127)));
			guard_buf.push_back(1'b0);
		end
		run_stream(1'b0);
	endtask

	// Headers with rate indexes above eleven are skipped while no frame has been found.
	// The first good frame uses the highest legal rate, and a later one with different
	// fields must not change what was latched.
	task automatic test_first_frame();
		for (int rate = 12; rate < 16; rate++) begin
			add_header(13'($urandom), 2'($urandom), 4'(rate), 3'($urandom), 1'($urandom), 1'b0);
			add_noise(1);
		end
		add_frame(24, 2'd1, AFS_RATE_MAX, 3'd7, 1'b1);
		add_frame(20, 2'd0, 4'd3, 3'd0, 1'b0);
		add_frame(11, 2'd2, 4'd8, 3'd2, 1'b0);
		run_stream(1'b0);
	endtask

	// Zero and very short length fields, lengths around the header size, and a header
	// with every field at its top value, which counts as a frame once one was found.
	task automatic test_frame_lengths();
		for (int flen = 0; flen < 6; flen++)
			add_random_frame(flen);
		add_noise(2);
		add_random_frame(6);
		add_random_frame(7);
		add_random_frame(10);
		add_frame(40, 2'd3, 4'd15, 3'd7, 1'b1);
		add_frame(11, 2'd0, 4'd0, 3'd0, 1'b0);
		run_stream(1'b0);
	endtask

	// Lengths at and below the current position: the scanner drops every byte.
	task automatic test_bytes_past_end();
		write_length(scan_pos);
		repeat (3) send_byte(8'($urandom));
		drain_records();
		write_length(32'd1);
		repeat (2) send_byte(8'($urandom));
		drain_records();
	endtask

	// Streams of random frames, short frames and noise. Each stream ends on a frame that
	// fills it exactly, so the scan carries on cleanly when the next length is written.
	// The middle stream runs with the largest length and so has no summary.
	task automatic test_random_streams(input int send_pct, input int recv_pct);
		int pick;
		gap_pct   = send_pct;
		stall_pct = recv_pct;
		for (int s = 0; s < 3; s++) begin
			while (stream_buf.size() < 50) begin
				pick = $urandom_range(99);
				if (pick < 55)
					add_random_frame($urandom_range(6, 48));
				else if (pick < 65)
					add_random_frame($urandom_range(0, 5));
				else if (pick < 70)
					add_random_frame($urandom_range(49, 300));
				else
					add_noise($urandom_range(1, 6));
			end
			add_random_frame($urandom_range(11, 40));
			run_stream(s == 1);
		end
	endtask

	// The largest length field, with the stream ending right after the minimum span.
	task automatic test_longest_frame();
		add_header(13'h1FFF, 2'd3, 4'd15, 3'd7, 1'b1, 1'b1);
		add_noise(5);
		run_stream(1'b0);
	endtask

	// The candidate now lies far beyond the new end, so good headers here are not seen.
	task automatic test_unreached_candidate();
		add_random_frame(12);
		add_random_frame(12);
		run_stream(1'b0);
	endtask

	// Random stalls on the record channel.
	always @(posedge clk)
		record_stall <= ($urandom_range(99) < stall_pct);

	// Every record taken is compared with the oldest pending prediction.
	always @(posedge clk) begin : check_records
		rec_t want;
		if (arst_n && record_valid && !record_stall) begin
			if (pending_records.size() == 0) begin
				report_mismatch("record_kind of a record nobody expected", record_kind, '0);
			end else begin
				want = pending_records.pop_front();
				if (record_kind !== want.kind)
					report_mismatch("record_kind", record_kind, want.kind);
				if (frame_number !== want.number)
					report_mismatch("frame_number", frame_number, want.number);
				if (frame_offset !== want.offset)
					report_mismatch("frame_offset", frame_offset, want.offset);
				if (frame_bytes !== want.bytes)
					report_mismatch("frame_bytes", frame_bytes, want.bytes);
				if (length_total !== want.total)
					report_mismatch("length_total", length_total, want.total);
				if (profile !== want.fields.profile)
					report_mismatch("profile", profile, want.fields.profile);
				if (rate_index !== want.fields.rate)
					report_mismatch("rate_index", rate_index, want.fields.rate);
				if (channel_config !== want.fields.chan)
					report_mismatch("channel_config", channel_config, want.fields.chan);
				if (mpeg_two !== want.fields.id)
					report_mismatch("mpeg_two", mpeg_two, want.fields.id);
				if (want.kind == KIND_FRAME)
					frames_checked++;
				else
					summaries_checked++;
			end
		end
	end

	// Test sequence. Reset is applied once; the scan state then carries across all
	// streams, each of which extends stream_length past the bytes already sent.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_at_reset();
		test_short_stream();
		test_first_frame();
		test_frame_lengths();
		test_bytes_past_end();
		test_random_streams(29, 68);
		test_random_streams(68, 29);
		test_random_streams(0, 0);
		test_longest_frame();
		test_unreached_candidate();
		$display("Scanned %0d stream bytes over %0d stream_length writes, zero and maximum included.",
			bytes_sent, lengths_written);
		$display("Checked %0d frame transactions and %0d end-of-scan transactions.",
			frames_checked, summaries_checked);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a scanner that stops delivering records or taking bytes.
	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/afs_pkg.sv
rtl/afs_window.sv
rtl/afs_scan.sv
rtl/adts_frame_scanner.sv
tb/adts_frame_scanner_tb.sv
